@@ hdl/lrutc_pkg.sv @@
// Shared constants for the LRU timestamp cache: opcodes, field widths,
// register map and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package lrutc_pkg;

   // Default sizes of the cache
   localparam int DEF_SLOTS       = 16;
   localparam int DEF_KEY_WIDTH   = 32;
   localparam int DEF_VALUE_WIDTH = 32;
   localparam int DEF_TIME_WIDTH  = 32;

   // Item fields of fixed width
   localparam int OPCODE_W = 2;
   localparam int CAP_W    = 5;
   localparam int FLAGS_W  = 2;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_GET   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PROBE = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd3;

   // Register map: one 32-bit register per word
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-3:0] REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

endpackage

@@ hdl/lru_timestamp_cache_top.sv @@
// Fully associative key/value cache with LRU replacement by access timestamps.
// Uses lrutc_pkg for opcodes, register map and default sizes.
`timescale 1ns / 1ps

// Each item is handled alone. A get, put or probe goes from acceptance to
// result in order, where n = min(capacity, SLOTS): latch the item, scan n
// slots while the single read port of the slot memory streams one slot per
// cycle into the match / first-empty / oldest search, and then write the
// touched slot back and load the result register once that register is free. A
// clear, or any item while the capacity is zero, skips the scan. The result
// register holds a finished result until it is taken, and the next item is
// accepted while it waits. Valid bits are flip-flops, cleared at reset and by
// clear; keys, values and times live in a synchronous memory. The access
// counter saturates, and equal times resolve to the lowest slot.
module lru_timestamp_cache_top #(
   parameter int SLOTS       = lrutc_pkg::DEF_SLOTS,
   parameter int KEY_WIDTH   = lrutc_pkg::DEF_KEY_WIDTH,
   parameter int VALUE_WIDTH = lrutc_pkg::DEF_VALUE_WIDTH,
   parameter int TIME_WIDTH  = lrutc_pkg::DEF_TIME_WIDTH,
   localparam int IDX_W      = $clog2(SLOTS + 1),
   localparam int REQ_DATA_W = ((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((2 * IDX_W + VALUE_WIDTH + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_DATA_W-1:0]              req_tdata,  // key, value_in, zero pad
   input  logic [lrutc_pkg::OPCODE_W-1:0]     req_tuser,  // opcode
   // result items
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [RSP_DATA_W-1:0]              rsp_tdata,  // slot_index, value_out,
                                                          // occupancy, zero pad
   output logic [lrutc_pkg::FLAGS_W-1:0]      rsp_tuser,  // hit, evicted
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [lrutc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lrutc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lrutc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready
);
   import lrutc_pkg::*;

   localparam int ADDR_W  = $clog2(SLOTS);
   localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH + TIME_WIDTH;
   localparam logic [IDX_W-1:0]      NONE_IDX = IDX_W'(SLOTS);
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   // control
   logic [1:0]             state_ff, state_in;
   logic [CAP_W-1:0]       capacity_ff;
   logic [SLOTS-1:0]       valid_ff, valid_in;
   logic [TIME_WIDTH-1:0]  access_ff, access_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;

   // item and scan registers
   logic [OPCODE_W-1:0]    op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [IDX_W-1:0]       n_ff, n_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [ADDR_W-1:0]      pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]       match_ff, match_in;
   logic [VALUE_WIDTH-1:0] match_val_ff, match_val_in;
   logic [IDX_W-1:0]       empty_ff, empty_in;
   logic [IDX_W-1:0]       oldest_ff, oldest_in;
   logic [TIME_WIDTH-1:0]  oldest_time_ff, oldest_time_in;
   logic [IDX_W-1:0]       count_ff, count_in;

   // result register
   logic                   rsp_hit_ff, rsp_hit_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;
   logic [IDX_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]       rsp_occ_ff, rsp_occ_in;

   // slot memory
   logic [ENTRY_W-1:0]     mem [SLOTS];
   logic [ENTRY_W-1:0]     rd_data_ff;
   logic                   rd_en;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [ENTRY_W-1:0]     mem_wdata;

   logic                   req_fire;
   logic                   out_free;
   logic [IDX_W-1:0]       active;
   logic [IDX_W-1:0]       pend_idx_ext;
   logic [KEY_WIDTH-1:0]   slot_key;
   logic [VALUE_WIDTH-1:0] slot_val;
   logic [TIME_WIDTH-1:0]  slot_time;
   logic [TIME_WIDTH-1:0]  time_next;
   logic [IDX_W-1:0]       target;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // slots in use: capacity clipped to the array size
   assign active = (32'(capacity_ff) > SLOTS) ? NONE_IDX : IDX_W'(capacity_ff);

   assign rd_en        = (state_ff == ST_SCAN) && (rd_idx_ff < n_ff);
   assign pend_idx_ext = IDX_W'(pend_idx_ff);
   assign slot_key     = rd_data_ff[KEY_WIDTH-1:0];
   assign slot_val     = rd_data_ff[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
   assign slot_time    = rd_data_ff[ENTRY_W-1:KEY_WIDTH+VALUE_WIDTH];
   assign time_next    = (access_ff == TIME_MAX) ? access_ff : access_ff + TIME_WIDTH'(1);
   assign target       = (empty_ff != NONE_IDX) ? empty_ff : oldest_ff;

   // sequencer: accept, scan slot by slot, then write back and report
   always_comb begin
      state_in       = state_ff;
      valid_in       = valid_ff;
      access_in      = access_ff;
      pend_in        = pend_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      op_in          = op_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      n_in           = n_ff;
      rd_idx_in      = rd_idx_ff;
      pend_idx_in    = pend_idx_ff;
      match_in       = match_ff;
      match_val_in   = match_val_ff;
      empty_in       = empty_ff;
      oldest_in      = oldest_ff;
      oldest_time_in = oldest_time_ff;
      count_in       = count_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_occ_in     = rsp_occ_ff;
      mem_we         = 1'b0;
      mem_waddr      = match_ff[ADDR_W-1:0];
      mem_wdata      = {time_next, match_val_ff, key_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser;
               key_in    = req_tdata[KEY_WIDTH-1:0];
               val_in    = req_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
               n_in      = active;
               rd_idx_in = '0;
               pend_in   = 1'b0;
               match_in  = NONE_IDX;
               empty_in  = NONE_IDX;
               oldest_in = NONE_IDX;
               count_in  = '0;
               state_in  = (req_tuser == OP_CLEAR || active == '0) ? ST_UPDATE : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // slot read in the previous cycle
            if (pend_ff) begin
               if (!valid_ff[pend_idx_ff]) begin
                  if (empty_ff == NONE_IDX) empty_in = pend_idx_ext;
               end else begin
                  count_in = count_ff + IDX_W'(1);
                  if (match_ff == NONE_IDX && slot_key == key_ff) begin
                     match_in     = pend_idx_ext;
                     match_val_in = slot_val;
                  end
                  if (oldest_ff == NONE_IDX || slot_time < oldest_time_ff) begin
                     oldest_in      = pend_idx_ext;
                     oldest_time_in = slot_time;
                  end
               end
            end
            if (rd_en) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in   = rd_idx_ff + IDX_W'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            if (out_free) begin
               rsp_tvalid_in  = 1'b1;
               rsp_hit_in     = 1'b0;
               rsp_evicted_in = 1'b0;
               rsp_slot_in    = NONE_IDX;
               rsp_value_in   = '0;
               rsp_occ_in     = count_ff;
               state_in       = ST_IDLE;
               case (op_ff) inside
                  OP_GET, OP_PROBE: begin
                     if (match_ff != NONE_IDX) begin
                        rsp_hit_in   = 1'b1;
                        rsp_slot_in  = match_ff;
                        rsp_value_in = match_val_ff;
                        if (op_ff == OP_GET) begin
                           mem_we    = 1'b1;
                           access_in = time_next;
                        end
                     end
                  end
                  OP_PUT: begin
                     if (match_ff != NONE_IDX) begin
                        rsp_hit_in  = 1'b1;
                        rsp_slot_in = match_ff;
                        mem_we      = 1'b1;
                        access_in   = time_next;
                     end else if (target != NONE_IDX) begin
                        // fill the first empty slot, else replace the oldest
                        rsp_evicted_in                  = (empty_ff == NONE_IDX);
                        rsp_slot_in                     = target;
                        valid_in[target[ADDR_W-1:0]]    = 1'b1;
                        mem_we                          = 1'b1;
                        mem_waddr                       = target[ADDR_W-1:0];
                        mem_wdata                       = {time_next, val_ff, key_ff};
                        access_in                       = time_next;
                        if (empty_ff != NONE_IDX) rsp_occ_in = count_ff + IDX_W'(1);
                     end
                  end
                  default: begin
                     valid_in   = '0;
                     rsp_occ_in = '0;
                  end
               endcase
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         access_ff     <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         access_ff     <= access_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // item, scan and result registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      n_ff           <= n_in;
      rd_idx_ff      <= rd_idx_in;
      pend_idx_ff    <= pend_idx_in;
      match_ff       <= match_in;
      match_val_ff   <= match_val_in;
      empty_ff       <= empty_in;
      oldest_ff      <= oldest_in;
      oldest_time_ff <= oldest_time_in;
      count_ff       <= count_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   // slot memory: key, value, time; one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_idx_ff[ADDR_W-1:0]];
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (psel && penable && pwrite && paddr[CSR_ADDR_W-1:2] == REG_CAPACITY) begin
         capacity_ff <= pwdata[CAP_W-1:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1:2] == REG_CAPACITY) ? CSR_DATA_W'(capacity_ff) : '0;
   assign pready = 1'b1;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_occ_ff, rsp_value_ff, rsp_slot_ff});
   assign rsp_tuser  = {rsp_evicted_ff, rsp_hit_ff};

`ifndef SYNTHESIS
   // a hit never evicts, and a hit or an eviction always names a slot
   a_hit_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("hit and eviction reported together");

   a_slot_named: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_hit_ff || rsp_evicted_ff)) |-> (rsp_slot_ff < NONE_IDX))
      else $error("hit or eviction without a slot");

   // occupancy count stays within the slots in use
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff <= n_ff))
      else $error("occupancy count beyond active slots");

   // the access clock never runs backward
   a_time_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (access_ff >= $past(access_ff)))
      else $error("access time decreased");

   // the slot memory is written only at the end of an item
   a_write_window: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_UPDATE && out_free))
      else $error("slot memory written outside write-back");
`endif

endmodule
